>>> rtl/core/bmpd_pkg.sv
package bmpd_pkg;

	// Default geometry limits and queue depth.
	localparam int DEF_MAX_WIDTH   = 4096;
	localparam int DEF_MAX_ROWS    = 4096;
	localparam int DEF_QUEUE_DEPTH = 4;

	// Field widths.
	localparam int INDEX_W      = 24;
	localparam int COLOR_W      = 24;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 24;
	localparam int CFG_SIZE_W   = 13;
	localparam int CFG_BPP_W    = 7;

	// Pixel formats and fixed numbers of the pixel array layout.
	localparam logic [CFG_BPP_W-1:0] BPP_MONO = 7'd1;
	localparam logic [CFG_BPP_W-1:0] BPP_TRUE = 7'd24;
	localparam int PIXELS_PER_BYTE = 8;
	localparam logic [2:0] BIT_MSB = 3'd7;
	localparam int ROW_ROUND  = 31;
	localparam int WORD_SHIFT = 5;
	localparam int ROW_MIN_BYTES = 4;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [7:0] ALPHA_CLEAR  = 8'd0;

	// Register reset values.
	localparam logic [CFG_SIZE_W-1:0] RST_IMAGE_WIDTH = 13'd1;
	localparam logic [CFG_SIZE_W-1:0] RST_IMAGE_ROWS  = 13'd1;
	localparam logic                  RST_FLIP_ROWS   = 1'b1;
	localparam logic [CFG_BPP_W-1:0]  RST_BPP         = 7'd24;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_WIDTH    = 3'd0,
		REG_IMAGE_ROWS     = 3'd1,
		REG_FLIP_ROWS      = 3'd2,
		REG_PIXEL_DEPTH    = 3'd3,
		REG_PALETTE_COLOR0 = 3'd4,
		REG_PALETTE_COLOR1 = 3'd5
	} cfg_reg_t;

	// Geometry settings seen by the front end.
	typedef struct packed {
		logic [CFG_SIZE_W-1:0] image_width;
		logic [CFG_SIZE_W-1:0] image_rows;
		logic                  flip_rows;
		logic [CFG_BPP_W-1:0]  pixel_depth;
	} front_cfg_t;

	// Palette seen by the back end, red in the top byte.
	typedef struct packed {
		logic [COLOR_W-1:0] color1;
		logic [COLOR_W-1:0] color0;
	} palette_t;

	// One queue job: a run of one to eight pixels from a byte, or one 24 bpp pixel.
	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic [2:0]         count_m1;
		logic               mono;
		logic               done;
		logic [COLOR_W-1:0] color;
	} job_t;

	// One pixel on its way out.
	typedef struct packed {
		logic [7:0]         alpha;
		logic [7:0]         blue;
		logic [7:0]         green;
		logic [7:0]         red;
		logic [INDEX_W-1:0] index;
		logic               last;
		logic               done;
	} pixel_t;

endpackage

>>> rtl/core/bmp_pixel_row_decoder.sv
// A byte that completes a pixel run is pushed into the queue, then into the output register.
// Throughput: one 24 bpp byte per cycle unless the queue is full; a 1 bpp byte yields
// up to eight pixels via the single-pixel output register, one per cycle unless stalled.
// A four-entry queue between classifier and pixel expander lets both sides stall apart.
// Reset clears counters, queue and output valid at once and loads the register defaults.
module bmp_pixel_row_decoder #(
	parameter int MAX_WIDTH   = bmpd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_ROWS    = bmpd_pkg::DEF_MAX_ROWS,
	parameter int QUEUE_DEPTH = bmpd_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration writes.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bmpd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bmpd_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Byte stream in.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // data_byte
	input  logic [0:0]                      s_tuser,  // frame_start
	// Pixel stream out.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [55:0]                     m_tdata,  // pixel_index, red, green, blue, alpha
	output logic                            m_tlast,  // last_of_run
	output logic [0:0]                      m_tuser   // image_done
);

	bmpd_pkg::front_cfg_t cfg_q;
	bmpd_pkg::palette_t   palette_q;
	bmpd_pkg::job_t       push_job, head_job;
	bmpd_pkg::pixel_t     pixel;
	logic                 job_push, pop, empty, full;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width <= bmpd_pkg::RST_IMAGE_WIDTH;
			cfg_q.image_rows  <= bmpd_pkg::RST_IMAGE_ROWS;
			cfg_q.flip_rows   <= bmpd_pkg::RST_FLIP_ROWS;
			cfg_q.pixel_depth <= bmpd_pkg::RST_BPP;
			palette_q.color0  <= '0;
			palette_q.color1  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (bmpd_pkg::cfg_reg_t'(cfg_index))
				bmpd_pkg::REG_IMAGE_WIDTH: begin
					cfg_q.image_width <= cfg_data[bmpd_pkg::CFG_SIZE_W-1:0];
				end
				bmpd_pkg::REG_IMAGE_ROWS: begin
					cfg_q.image_rows <= cfg_data[bmpd_pkg::CFG_SIZE_W-1:0];
				end
				bmpd_pkg::REG_FLIP_ROWS: begin
					cfg_q.flip_rows <= cfg_data[0];
				end
				bmpd_pkg::REG_PIXEL_DEPTH: begin
					cfg_q.pixel_depth <= cfg_data[bmpd_pkg::CFG_BPP_W-1:0];
				end
				bmpd_pkg::REG_PALETTE_COLOR0: begin
					palette_q.color0 <= cfg_data;
				end
				bmpd_pkg::REG_PALETTE_COLOR1: begin
					palette_q.color1 <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	bmpd_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_ROWS  (MAX_ROWS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.frame_start (s_tuser[0]),
		.data_byte   (s_tdata),
		.queue_full  (full),
		.job_push    (job_push),
		.job         (push_job)
	);

	bmpd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.empty    (empty),
		.full     (full)
	);

	bmpd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.palette  (palette_q),
		.head_job (head_job),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.pixel    (pixel)
	);

	// Output packing, pixel index in the lowest bits.
	assign m_tdata    = {pixel.alpha, pixel.blue, pixel.green, pixel.red, pixel.index};
	assign m_tlast    = pixel.last;
	assign m_tuser[0] = pixel.done;

endmodule

>>> rtl/core/bmpd_front.sv
module bmpd_front #(
	parameter int MAX_WIDTH = bmpd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_ROWS  = bmpd_pkg::DEF_MAX_ROWS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bmpd_pkg::front_cfg_t  cfg,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic                  frame_start,
	input  logic [7:0]            data_byte,
	input  logic                  queue_full,
	output logic                  job_push,
	output bmpd_pkg::job_t        job
);

	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int RW  = $clog2(MAX_ROWS + 1);
	localparam int PW  = bmpd_pkg::CFG_BPP_W + WW;
	localparam int RSW = $clog2(((127 * MAX_WIDTH + bmpd_pkg::ROW_ROUND) / 32) * 4 + 1);

	typedef enum logic [1:0] {
		PH_BLUE,
		PH_GREEN,
		PH_RED
	} phase_t;

	logic [WW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [RSW-1:0] rbc_q;
	phase_t         phase_q;
	logic [7:0]     blue_q;
	logic [7:0]     green_q;
	logic           fin_q;

	logic [WW-1:0]  w_c;
	logic [RW-1:0]  r_c;
	logic [PW-1:0]  row_bits_c;
	logic [PW:0]    row_bits_rnd_c;
	logic [PW:0]    row_words_c;
	logic [RSW-1:0] row_size_c;

	logic [WW-1:0]  col_e, col_n, rem_c;
	logic [RW-1:0]  row_e, row_n, base_row_c;
	logic [RSW-1:0] rbc_e, rbc_n;
	logic [RSW:0]   rbc_inc_c;
	phase_t         phase_e, phase_n;
	logic [7:0]     blue_e, blue_n, green_e, green_n;
	logic           fin_e, fin_n, fin_chk_c;
	logic           col_lt_c, last_row_c, row_end_c, emit_c, accept_c;
	logic [3:0]     mono_n_c;
	logic [RW+WW-1:0] base_prod_c;

	// Width and row count saturated to their legal ranges.
	always_comb begin
		if (cfg.image_width == '0) begin
			w_c = WW'(1);
		end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
			w_c = WW'(MAX_WIDTH);
		end else begin
			w_c = WW'(cfg.image_width);
		end
		if (cfg.image_rows == '0) begin
			r_c = RW'(1);
		end else if (32'(cfg.image_rows) > 32'(MAX_ROWS)) begin
			r_c = RW'(MAX_ROWS);
		end else begin
			r_c = RW'(cfg.image_rows);
		end
	end

	// Stored row length in bytes, rounded up to whole 32-bit words.
	assign row_bits_c     = PW'(cfg.pixel_depth) * PW'(w_c);
	assign row_bits_rnd_c = {1'b0, row_bits_c} + (PW + 1)'(bmpd_pkg::ROW_ROUND);
	assign row_words_c    = row_bits_rnd_c >> bmpd_pkg::WORD_SHIFT;
	assign row_size_c     = (row_words_c == '0) ? RSW'(bmpd_pkg::ROW_MIN_BYTES)
	                                            : RSW'({row_words_c, 2'b00});

	// A frame start clears the counters before the byte is taken.
	assign col_e   = frame_start ? '0 : col_q;
	assign row_e   = frame_start ? '0 : row_q;
	assign rbc_e   = frame_start ? '0 : rbc_q;
	assign phase_e = frame_start ? PH_BLUE : phase_q;
	assign blue_e  = frame_start ? '0 : blue_q;
	assign green_e = frame_start ? '0 : green_q;
	assign fin_e   = frame_start ? 1'b0 : fin_q;

	assign fin_chk_c  = fin_e || (row_e >= r_c);
	assign col_lt_c   = col_e < w_c;
	assign rem_c      = w_c - col_e;
	assign last_row_c = (row_e + RW'(1)) == r_c;
	assign mono_n_c   = (32'(rem_c) >= 32'(bmpd_pkg::PIXELS_PER_BYTE))
	                    ? 4'(bmpd_pkg::PIXELS_PER_BYTE) : 4'(rem_c);
	assign rbc_inc_c  = {1'b0, rbc_e} + (RSW + 1)'(1);
	assign row_end_c  = rbc_inc_c >= {1'b0, row_size_c};

	// Index of the first pixel of this byte.
	assign base_row_c  = cfg.flip_rows ? (r_c - RW'(1) - row_e) : row_e;
	assign base_prod_c = (RW + WW)'(base_row_c) * (RW + WW)'(w_c);

	// Classify the byte and work out the next counter values.
	always_comb begin
		col_n        = col_e;
		row_n        = row_e;
		rbc_n        = rbc_e;
		phase_n      = phase_e;
		blue_n       = blue_e;
		green_n      = green_e;
		fin_n        = fin_chk_c;
		emit_c       = 1'b0;
		job.index    = bmpd_pkg::INDEX_W'(base_prod_c) + bmpd_pkg::INDEX_W'(col_e);
		job.count_m1 = '0;
		job.mono     = 1'b0;
		job.done     = 1'b0;
		job.color    = {16'b0, data_byte};
		if (!fin_chk_c) begin
			if (cfg.pixel_depth == bmpd_pkg::BPP_MONO) begin
				if (col_lt_c) begin
					emit_c       = 1'b1;
					job.mono     = 1'b1;
					job.count_m1 = 3'(mono_n_c - 4'd1);
					job.done     = last_row_c
					               && (32'(rem_c) <= 32'(bmpd_pkg::PIXELS_PER_BYTE));
					col_n        = col_e + WW'(mono_n_c);
				end
			end else if (cfg.pixel_depth == bmpd_pkg::BPP_TRUE) begin
				if (col_lt_c) begin
					case (phase_e)
						PH_BLUE: begin
							blue_n  = data_byte;
							phase_n = PH_GREEN;
						end
						PH_GREEN: begin
							green_n = data_byte;
							phase_n = PH_RED;
						end
						default: begin
							emit_c    = 1'b1;
							job.color = {data_byte, green_e, blue_e};
							job.done  = last_row_c && (rem_c == WW'(1));
							col_n     = col_e + WW'(1);
							phase_n   = PH_BLUE;
						end
					endcase
				end
			end
			rbc_n = rbc_inc_c[RSW-1:0];
			if (row_end_c) begin
				rbc_n   = '0;
				col_n   = '0;
				phase_n = PH_BLUE;
				row_n   = row_e + RW'(1);
				fin_n   = (row_e + RW'(1)) >= r_c;
			end
		end
	end

	assign s_tready = !queue_full;
	assign accept_c = s_tvalid && s_tready;
	assign job_push = accept_c && emit_c;

	// Row and column state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			rbc_q   <= '0;
			phase_q <= PH_BLUE;
			blue_q  <= '0;
			green_q <= '0;
			fin_q   <= 1'b0;
		end else if (accept_c) begin
			col_q   <= col_n;
			row_q   <= row_n;
			rbc_q   <= rbc_n;
			phase_q <= phase_n;
			blue_q  <= blue_n;
			green_q <= green_n;
			fin_q   <= fin_n;
		end
	end

endmodule

>>> rtl/core/bmpd_fifo.sv
module bmpd_fifo #(
	parameter int DEPTH = bmpd_pkg::DEF_QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bmpd_pkg::job_t push_job,
	input  logic           pop,
	output bmpd_pkg::job_t head_job,
	output logic           empty,
	output logic           full
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	bmpd_pkg::job_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty    = count_q == '0;
	assign full     = count_q == CNT_W'(DEPTH);
	assign head_job = entry_q[rd_ptr_q];

	// Entry storage, written at the tail.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// The front end never writes a full queue, the back end never reads an empty one.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("request written into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("request read from an empty queue");

endmodule

>>> rtl/core/bmpd_back.sv
module bmpd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  bmpd_pkg::palette_t palette,
	input  bmpd_pkg::job_t     head_job,
	input  logic               empty,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output bmpd_pkg::pixel_t   pixel
);

	logic [2:0]       k_q;
	logic             valid_q;
	bmpd_pkg::pixel_t pixel_q;
	bmpd_pkg::pixel_t pixel_c;
	logic             load_c, last_c, bit_c;
	logic [7:0]       mono_byte_c;
	logic [bmpd_pkg::COLOR_W-1:0] rgb_c;

	assign load_c      = !empty && (!valid_q || m_tready);
	assign last_c      = k_q == head_job.count_m1;
	assign pop         = load_c && last_c;
	assign mono_byte_c = head_job.color[7:0];
	assign bit_c       = mono_byte_c[bmpd_pkg::BIT_MSB - k_q];

	// Build the current pixel of the run at the head of the queue.
	always_comb begin
		if (head_job.mono) begin
			rgb_c         = bit_c ? palette.color1 : palette.color0;
			pixel_c.alpha = bmpd_pkg::ALPHA_CLEAR;
		end else begin
			rgb_c         = head_job.color;
			pixel_c.alpha = bmpd_pkg::ALPHA_OPAQUE;
		end
		pixel_c.red   = rgb_c[23:16];
		pixel_c.green = rgb_c[15:8];
		pixel_c.blue  = rgb_c[7:0];
		pixel_c.index = head_job.index + bmpd_pkg::INDEX_W'(k_q);
		pixel_c.last  = last_c;
		pixel_c.done  = last_c && head_job.done;
	end

	// Pixel position within the run and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load_c) begin
				k_q     <= last_c ? '0 : k_q + 3'd1;
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output pixel register.
	always_ff @(posedge clk) begin
		if (load_c) begin
			pixel_q <= pixel_c;
		end
	end

	assign m_tvalid = valid_q;
	assign pixel    = pixel_q;

	// A run that has started stays at the head until its last pixel leaves.
	a_run_held: assert property (@(posedge clk) disable iff (!arst_n) (k_q != '0) |-> !empty)
		else $error("queue head lost in the middle of a run");
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (k_q <= head_job.count_m1))
		else $error("pixel position beyond the run length");

endmodule
